/* sv/rpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types and codes of the rational polyphase resampler.
// ----------------------------------------------------------------------------
package rpr_pkg;

   localparam int UP_WIDTH         = 7;
   localparam int DOWN_WIDTH       = 12;
   localparam int TAPS_WIDTH       = 7;
   localparam int COEF_INDEX_WIDTH = 12;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 12;
   localparam int MAX_RESULTS      = 64;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UP_FACTOR   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOWN_FACTOR = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TAPS        = 2'd2;

   localparam logic [UP_WIDTH-1:0]   UP_RESET   = 7'd1;
   localparam logic [DOWN_WIDTH-1:0] DOWN_RESET = 12'd1;
   localparam logic [TAPS_WIDTH-1:0] TAPS_RESET = 7'd16;

   typedef struct packed {
      logic [UP_WIDTH-1:0]   up_factor;
      logic [DOWN_WIDTH-1:0] down_factor;
      logic [TAPS_WIDTH-1:0] taps_in_branch;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_WRITE,
      ST_BASE,
      ST_MAC,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

/* sv/rpr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rpr_req_if #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
);
   import rpr_pkg::*;

   logic                               valid;
   logic                               ready;
   logic                               op;
   logic signed [SAMPLE_WIDTH-1:0]     sample_i;
   logic signed [SAMPLE_WIDTH-1:0]     sample_q;
   logic        [COEF_INDEX_WIDTH-1:0] coef_index;
   logic signed [COEF_WIDTH-1:0]       coef_value;

   modport source (output valid, op, sample_i, sample_q, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, op, sample_i, sample_q, coef_index, coef_value,
                   output ready);
endinterface

interface rpr_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_i;
   logic signed [SAMPLE_WIDTH-1:0] out_q;
   logic                           last;

   modport source (output valid, out_i, out_q, last, input ready);
   modport sink   (input valid, out_i, out_q, last, output ready);
endinterface

/* sv/rpr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/rpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_front
// Accepts request items, drops coefficient writes outside the store and
// queues the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rpr_front #(
   parameter int MAX_UP       = 64,
   parameter int MAX_TAPS     = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic clock,
   input  logic reset,
   rpr_req_if.sink   req,
   rpr_req_if.source que
);
   import rpr_pkg::*;

   localparam int STORE_SIZE = MAX_UP * MAX_TAPS;

   logic                               op_ff    [2];
   logic signed [SAMPLE_WIDTH-1:0]     si_ff    [2];
   logic signed [SAMPLE_WIDTH-1:0]     sq_ff    [2];
   logic        [COEF_INDEX_WIDTH-1:0] cidx_ff  [2];
   logic signed [COEF_WIDTH-1:0]       cval_ff  [2];
   logic                               wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]                         cnt_ff, cnt_in;
   logic                               accept, push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign accept    = req.valid && req.ready;
   // A coefficient write beyond the store has no effect, so it is not queued.
   assign push = accept && !(req.op == OP_COEF &&
                             32'(req.coef_index) >= STORE_SIZE);
   assign pop  = que.valid && que.ready;

   assign que.valid      = (cnt_ff != 2'd0);
   assign que.op         = op_ff[rd_ff];
   assign que.sample_i   = si_ff[rd_ff];
   assign que.sample_q   = sq_ff[rd_ff];
   assign que.coef_index = cidx_ff[rd_ff];
   assign que.coef_value = cval_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ff]   <= req.op;
         si_ff[wr_ff]   <= req.sample_i;
         sq_ff[wr_ff]   <= req.sample_q;
         cidx_ff[wr_ff] <= req.coef_index;
         cval_ff[wr_ff] <= req.coef_value;
      end
   end
endmodule

/* sv/rpr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_back
// Executes queued items: coefficient writes, delay line updates and the
// multiply-accumulate, phase division and output of up to MAX_RESULTS due results.
// ----------------------------------------------------------------------------
module rpr_back #(
   parameter int MAX_UP       = 64,
   parameter int MAX_TAPS     = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  rpr_pkg::cfg_type cfg,
   rpr_req_if.sink          que,
   rpr_rsp_if.source        rsp
);
   import rpr_pkg::*;

   localparam int PW    = $clog2(MAX_UP + 1);
   localparam int LW    = $clog2(MAX_TAPS + 1);
   localparam int PTRW  = $clog2(MAX_TAPS);
   localparam int PHW   = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;
   localparam int TW    = $clog2(MAX_UP + 4095);
   localparam int DCW   = $clog2(TW + 1);
   localparam int AW    = $clog2(MAX_UP * MAX_TAPS);
   localparam int CNTW  = $clog2(MAX_RESULTS + 1);
   localparam int PRW   = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACCW  = PRW + LW;
   localparam int FRAC  = COEF_WIDTH - 2;
   localparam logic signed [ACCW-1:0] HALF = ACCW'(1) <<< (FRAC - 1);
   localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [ACCW-1:0] acc);
      logic signed [ACCW-1:0] r;
      r = (acc + HALF) >>> FRAC;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   // Effective register values.
   logic [PW-1:0]         p_eff;
   logic [DOWN_WIDTH-1:0] q_eff;
   logic [LW-1:0]         len_eff;

   always_comb begin
      if (cfg.up_factor == '0) begin
         p_eff = PW'(1);
      end else if (32'(cfg.up_factor) > MAX_UP) begin
         p_eff = PW'(MAX_UP);
      end else begin
         p_eff = PW'(cfg.up_factor);
      end
      q_eff = (cfg.down_factor == '0) ? DOWN_WIDTH'(1) : cfg.down_factor;
      if (cfg.taps_in_branch == '0) begin
         len_eff = LW'(1);
      end else if (32'(cfg.taps_in_branch) > MAX_TAPS) begin
         len_eff = LW'(MAX_TAPS);
      end else begin
         len_eff = LW'(cfg.taps_in_branch);
      end
   end

   state_type state_ff, state_in;

   logic [PTRW-1:0]  wp_ff, wp_in;
   logic [PHW-1:0]   oph_ff, oph_in;
   logic [TW-1:0]    need_ff, need_in;
   logic [MAX_TAPS-1:0] dv_ff, dv_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             s1_ff, s1_in, s2_ff, s2_in;
   logic             rv_ff, rv_in;

   logic [PTRW-1:0]  ptr_ff, ptr_in, idx_ff, idx_in;
   logic [PHW-1:0]   ph_ff, ph_in;
   logic signed [SAMPLE_WIDTH-1:0] si_ff, si_in, sq_ff, sq_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [LW-1:0]    k_ff, k_in;
   logic             dvr_ff, dvr_in;
   logic signed [PRW-1:0]  pi_ff, pi_in, pq_ff, pq_in;
   logic signed [ACCW-1:0] ai_ff, ai_in, aq_ff, aq_in;
   logic [TW-1:0]    quo_ff, quo_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [DCW-1:0]   dc_ff, dc_in;
   logic signed [SAMPLE_WIDTH-1:0] oi_ff, oi_in, oq_ff, oq_in;
   logic             last_ff, last_in;

   // Memories.
   logic                    cram_we;
   logic [AW-1:0]           cram_raddr;
   logic [COEF_WIDTH-1:0]   cram_rdata;
   logic                    dram_we;
   logic [PTRW-1:0]         dram_raddr;
   logic [2*SAMPLE_WIDTH-1:0] dram_rdata;

   rpr_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_UP * MAX_TAPS)) u_coef_ram (
      .clock (clock),
      .we    (cram_we),
      .waddr (AW'(que.coef_index)),
      .wdata (que.coef_value),
      .raddr (cram_raddr),
      .rdata (cram_rdata)
   );

   rpr_ram #(.WIDTH(2 * SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_delay_ram (
      .clock (clock),
      .we    (dram_we),
      .waddr (ptr_ff),
      .wdata ({si_ff, sq_ff}),
      .raddr (dram_raddr),
      .rdata (dram_rdata)
   );

   logic pop, issue, mac_done, mod_done, out_free, emit_more;
   logic [PW:0] rem_sh;
   logic [PTRW-1:0] ptr_next;
   logic [TW-1:0]   need_dec;
   logic signed [SAMPLE_WIDTH-1:0] d_i, d_q;

   assign que.ready = (state_ff == ST_IDLE);
   assign pop       = que.valid && que.ready;
   assign issue     = (k_ff != len_eff);
   assign mac_done  = !issue && !s1_ff && !s2_ff;
   assign mod_done  = (32'(ptr_ff) < 32'(len_eff)) && (32'(ph_ff) < 32'(p_eff));
   assign out_free  = !rv_ff || rsp.ready;
   assign emit_more = (quo_ff == '0) && (32'(count_ff) + 1 < MAX_RESULTS);
   assign rem_sh    = {rem_ff, quo_ff[TW-1]};
   assign ptr_next  = (32'(ptr_ff) + 1 == 32'(len_eff)) ? '0 : ptr_ff + PTRW'(1);
   assign need_dec  = (need_ff != '0) ? need_ff - TW'(1) : '0;
   assign d_i       = dvr_ff ? $signed(dram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]) : '0;
   assign d_q       = dvr_ff ? $signed(dram_rdata[SAMPLE_WIDTH-1:0]) : '0;

   assign cram_we    = pop && (que.op == OP_COEF);
   assign cram_raddr = base_ff + AW'(k_ff);
   assign dram_we    = (state_ff == ST_WRITE);
   assign dram_raddr = idx_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (pop && que.op == OP_SAMPLE) state_in = ST_MOD;
         ST_MOD:   if (mod_done) state_in = ST_WRITE;
         ST_WRITE: state_in = (need_dec == '0) ? ST_BASE : ST_IDLE;
         ST_BASE:  state_in = ST_MAC;
         ST_MAC:   if (mac_done) state_in = ST_DIV;
         ST_DIV:   if (dc_ff == '0) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = emit_more ? ST_BASE : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      wp_in    = wp_ff;
      oph_in   = oph_ff;
      need_in  = need_ff;
      dv_in    = dv_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      si_in    = si_ff;
      sq_in    = sq_ff;
      base_in  = base_ff;
      k_in     = k_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dc_in    = dc_ff;
      oi_in    = oi_ff;
      oq_in    = oq_ff;
      last_in  = last_ff;
      rv_in    = rv_ff && !rsp.ready;
      s1_in    = (state_ff == ST_MAC) && issue;
      s2_in    = s1_ff;
      dvr_in   = dv_ff[idx_ff];
      pi_in    = $signed(cram_rdata) * d_i;
      pq_in    = $signed(cram_rdata) * d_q;
      ai_in    = s2_ff ? ai_ff + ACCW'(pi_ff) : ai_ff;
      aq_in    = s2_ff ? aq_ff + ACCW'(pq_ff) : aq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && que.op == OP_SAMPLE) begin
               si_in  = que.sample_i;
               sq_in  = que.sample_q;
               ptr_in = wp_ff;
               ph_in  = oph_ff;
            end
         end
         ST_MOD: begin
            if (32'(ptr_ff) >= 32'(len_eff)) begin
               ptr_in = PTRW'(32'(ptr_ff) - 32'(len_eff));
            end
            if (32'(ph_ff) >= 32'(p_eff)) begin
               ph_in = PHW'(32'(ph_ff) - 32'(p_eff));
            end
         end
         ST_WRITE: begin
            dv_in[ptr_ff] = 1'b1;
            ptr_in   = ptr_next;
            wp_in    = ptr_next;
            need_in  = need_dec;
            count_in = '0;
            if (need_dec != '0) begin
               oph_in = ph_ff;
            end
         end
         ST_BASE: begin
            base_in = AW'(32'(ph_ff) * 32'(len_eff));
            k_in    = '0;
            idx_in  = (ptr_ff == '0) ? PTRW'(len_eff - LW'(1)) : ptr_ff - PTRW'(1);
            ai_in   = '0;
            aq_in   = '0;
         end
         ST_MAC: begin
            if (issue) begin
               k_in   = k_ff + LW'(1);
               idx_in = (idx_ff == '0) ? PTRW'(len_eff - LW'(1)) : idx_ff - PTRW'(1);
            end
            if (mac_done) begin
               quo_in = TW'(ph_ff) + TW'(q_eff);
               rem_in = '0;
               dc_in  = DCW'(TW);
            end
         end
         ST_DIV: begin
            if (dc_ff != '0) begin
               if (rem_sh >= {1'b0, p_eff}) begin
                  rem_in = PW'(rem_sh - {1'b0, p_eff});
                  quo_in = {quo_ff[TW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[PW-1:0];
                  quo_in = {quo_ff[TW-2:0], 1'b0};
               end
               dc_in = dc_ff - DCW'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               oi_in    = round_sat(ai_ff);
               oq_in    = round_sat(aq_ff);
               last_in  = !emit_more;
               rv_in    = 1'b1;
               need_in  = quo_ff;
               ph_in    = PHW'(rem_ff);
               count_in = count_ff + CNTW'(1);
               if (!emit_more) begin
                  oph_in = PHW'(rem_ff);
               end
            end
         end
         default: begin
            rv_in = rv_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         oph_ff   <= '0;
         need_ff  <= TW'(1);
         dv_ff    <= '0;
         count_ff <= '0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         oph_ff   <= oph_in;
         need_ff  <= need_in;
         dv_ff    <= dv_in;
         count_ff <= count_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      idx_ff  <= idx_in;
      ph_ff   <= ph_in;
      si_ff   <= si_in;
      sq_ff   <= sq_in;
      base_ff <= base_in;
      k_ff    <= k_in;
      dvr_ff  <= dvr_in;
      pi_ff   <= pi_in;
      pq_ff   <= pq_in;
      ai_ff   <= ai_in;
      aq_ff   <= aq_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dc_ff   <= dc_in;
      oi_ff   <= oi_in;
      oq_ff   <= oq_in;
      last_ff <= last_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.out_i = oi_ff;
   assign rsp.out_q = oq_ff;
   assign rsp.last  = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_RESULTS))
      else $error("result count exceeded its limit");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (32'(ptr_ff) < 32'(len_eff)))
      else $error("delay write pointer outside the active line");

   a_emit_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff < p_eff))
      else $error("phase remainder not below the up factor");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (dv_ff != '0))
      else $error("delay entry not marked after a write");
endmodule

/* sv/polyphase_rational_resampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Rational P/Q polyphase FIR resampler for I/Q sample pairs.
// ----------------------------------------------------------------------------
// Items arrive on req_ch (valid/ready). An item with op = 0 carries an I/Q
// sample pair, one with op = 1 writes a coefficient. Results leave on rsp_ch,
// zero to 64 per sample item, the final one of each item flagged by last.
// Registers up_factor, down_factor and taps_in_branch are written through the
// csr_ port by the user, only while the block is idle; the block does not check.
// A two-entry queue parts the front end from the processing engine, so items
// are taken while a result still waits at the output register.
// A coefficient item is written to its RAM as the engine takes it. A sample
// item goes through pointer and phase reduction after a register change and
// is written to the delay line; every result then needs one coefficient and
// delay line read per tap through the single read ports of the two RAMs,
// a three-stage multiply-accumulate drain and a 13-step phase division.
// At reset the delay lines read as zero, the phase is zero and the first
// sample item produces a result; coefficients are undefined until written.
// A stalled receiver holds the engine at its output step; the queue then
// fills and req_ch.ready drops.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler #(
   parameter int MAX_UP       = 64,
   parameter int MAX_TAPS     = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rpr_req_if.sink                             req_ch,
   rpr_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [rpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rpr_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import rpr_pkg::*;

   // Configuration registers, kept as written; the engine clamps them.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_UP_FACTOR:   cfg_in.up_factor      = csr_data[UP_WIDTH-1:0];
            REG_DOWN_FACTOR: cfg_in.down_factor    = csr_data[DOWN_WIDTH-1:0];
            REG_TAPS:        cfg_in.taps_in_branch = csr_data[TAPS_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_factor      <= UP_RESET;
         cfg_ff.down_factor    <= DOWN_RESET;
         cfg_ff.taps_in_branch <= TAPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Queue between front end and engine.
   rpr_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) que_ch ();

   rpr_front #(
      .MAX_UP       (MAX_UP),
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .que   (que_ch)
   );

   rpr_back #(
      .MAX_UP       (MAX_UP),
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .que   (que_ch),
      .rsp   (rsp_ch)
   );
endmodule
